FILE: hdl/bsr_pkg.sv
package bsr_pkg;

	// Field and register widths
	localparam int CFG_W = 9;
	localparam int BS_W  = 3;
	localparam int CNT_W = 17;
	localparam int VAL_W = 32;

	// Parameter defaults
	localparam int MAX_ROWS_DEF  = 256;
	localparam int MAX_COLS_DEF  = 256;
	localparam int MAX_BLOCK_DEF = 4;

	// Queue depths
	localparam int CMD_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	// Register reset values
	localparam logic [CFG_W-1:0] RESET_ROW_COUNT    = 9'd256;
	localparam logic [CFG_W-1:0] RESET_COLUMN_COUNT = 9'd256;
	localparam logic [BS_W-1:0]  RESET_BLOCK_SIZE   = 3'd2;

	// Register indexes
	localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
	localparam logic [1:0] REG_BLOCK_SIZE   = 2'd2;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PTR = 2'd0,
		KIND_COL = 2'd1,
		KIND_VAL = 2'd2
	} kind_t;

	// Work for the back end, one entry per element that makes results
	typedef struct packed {
		logic             has_start;
		logic [CNT_W-1:0] start_cnt;
		logic             has_block;
		logic [CFG_W-1:0] blk_col;
		logic [CFG_W-1:0] col0;
		logic             has_end;
		logic [CNT_W-1:0] end_cnt;
	} cmd_t;

	typedef struct packed {
		kind_t            kind;
		logic [CNT_W-1:0] pos;
		logic [VAL_W-1:0] value;
		logic             last;
	} result_t;

endpackage

FILE: hdl/bsr_fifo.sv
module bsr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	output logic                         full,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: hdl/bsr_ram.sv
module bsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/bsr_front.sv
module bsr_front #(
	parameter int MAX_COLS = bsr_pkg::MAX_COLS_DEF,
	parameter int ADDR_W   = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  logic [bsr_pkg::CFG_W-1:0]   rows,
	input  logic [bsr_pkg::CFG_W-1:0]   cols,
	input  logic [bsr_pkg::BS_W-1:0]    bs,
	input  logic                        push,
	input  logic [bsr_pkg::VAL_W-1:0]   element_value,
	output logic                        full,
	output bsr_pkg::cmd_t               cmd,
	output logic                        cmd_push,
	input  logic                        cmd_full,
	output logic                        ram_we,
	output logic [ADDR_W-1:0]           ram_waddr,
	output logic [bsr_pkg::VAL_W-1:0]   ram_wdata,
	input  logic                        blk_read_done
);

	localparam int MIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CW  = bsr_pkg::CFG_W;
	localparam int BW  = bsr_pkg::BS_W;
	localparam int NW  = bsr_pkg::CNT_W;

	logic [CW-1:0]       r_q;
	logic [CW-1:0]       c_q;
	logic [CW-1:0]       r0_q;
	logic [CW-1:0]       c0_q;
	logic [BW-1:0]       br_q;
	logic [BW-1:0]       cc_q;
	logic [CW-1:0]       bc_q;
	logic [ADDR_W-1:0]   rowoff_q;
	logic [NW-1:0]       total_q;
	logic [MAX_COLS-1:0] marks_q;
	logic                pend_q;
	logic [CW-1:0]       pend_bc_q;

	logic          blk_row_ok;
	logic          blk_col_ok;
	logic          in_blk;
	logic          start_ptr;
	logic          blk_end;
	logic          nz;
	logic          push_blk;
	logic          last_elem;
	logic          hazard;
	logic          accept;
	logic [MIW-1:0] bc_idx;
	logic [NW-1:0] total_nx;

	// Classify the element at the current position
	always_comb begin
		blk_row_ok = ({1'b0, r0_q} + (CW+1)'(bs)) <= {1'b0, rows};
		blk_col_ok = ({1'b0, c0_q} + (CW+1)'(bs)) <= {1'b0, cols};
		in_blk     = blk_row_ok && blk_col_ok;
		start_ptr  = blk_row_ok && (br_q == '0) && (c_q == '0);
		blk_end    = in_blk && (br_q == bs - BW'(1)) && (cc_q == bs - BW'(1));
		bc_idx     = MIW'(bc_q);
		nz         = (element_value != '0);
		push_blk   = blk_end && (marks_q[bc_idx] || nz);
		last_elem  = (r_q >= rows - CW'(1)) && (c_q >= cols - CW'(1));
		total_nx   = total_q + NW'(push_blk);
		// hold elements that would overwrite a block still being read, or close a block meanwhile
		hazard     = pend_q && in_blk && ((bc_q == pend_bc_q) || blk_end);
		full       = cmd_full || hazard;
		accept     = push && !full;
	end

	// Build the request for the back end and the store write
	always_comb begin
		cmd.has_start = start_ptr;
		cmd.start_cnt = total_q;
		cmd.has_block = push_blk;
		cmd.blk_col   = bc_q;
		cmd.col0      = c0_q;
		cmd.has_end   = last_elem;
		cmd.end_cnt   = total_nx;
		cmd_push      = accept && (start_ptr || push_blk || last_elem);
		ram_we        = accept && in_blk;
		ram_waddr     = rowoff_q + ADDR_W'(c_q);
		ram_wdata     = element_value;
	end

	// Track positions, marks, block total and the pending block read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q       <= '0;
			c_q       <= '0;
			r0_q      <= '0;
			c0_q      <= '0;
			br_q      <= '0;
			cc_q      <= '0;
			bc_q      <= '0;
			rowoff_q  <= '0;
			total_q   <= '0;
			marks_q   <= '0;
			pend_q    <= 1'b0;
			pend_bc_q <= '0;
		end else if (restart) begin
			r_q      <= '0;
			c_q      <= '0;
			r0_q     <= '0;
			c0_q     <= '0;
			br_q     <= '0;
			cc_q     <= '0;
			bc_q     <= '0;
			rowoff_q <= '0;
			total_q  <= '0;
			marks_q  <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (blk_read_done) begin
				pend_q <= 1'b0;
			end
			if (accept) begin
				if (push_blk) begin
					pend_q    <= 1'b1;
					pend_bc_q <= bc_q;
				end
				if (in_blk) begin
					if (blk_end) begin
						marks_q[bc_idx] <= 1'b0;
					end else if (nz) begin
						marks_q[bc_idx] <= 1'b1;
					end
				end
				total_q <= total_nx;
				if (last_elem) begin
					// end of matrix: start over
					r_q      <= '0;
					c_q      <= '0;
					r0_q     <= '0;
					c0_q     <= '0;
					br_q     <= '0;
					cc_q     <= '0;
					bc_q     <= '0;
					rowoff_q <= '0;
					total_q  <= '0;
					marks_q  <= '0;
				end else if (c_q == cols - CW'(1)) begin
					c_q  <= '0;
					c0_q <= '0;
					cc_q <= '0;
					bc_q <= '0;
					r_q  <= r_q + CW'(1);
					if (br_q == bs - BW'(1)) begin
						br_q     <= '0;
						r0_q     <= r_q + CW'(1);
						rowoff_q <= '0;
					end else begin
						br_q     <= br_q + BW'(1);
						rowoff_q <= rowoff_q + ADDR_W'(MAX_COLS);
					end
				end else begin
					c_q <= c_q + CW'(1);
					if (cc_q == bs - BW'(1)) begin
						cc_q <= '0;
						bc_q <= bc_q + CW'(1);
						c0_q <= c_q + CW'(1);
					end else begin
						cc_q <= cc_q + BW'(1);
					end
				end
			end
		end
	end

endmodule

FILE: hdl/bsr_back.sv
module bsr_back #(
	parameter int MAX_COLS = bsr_pkg::MAX_COLS_DEF,
	parameter int ADDR_W   = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bsr_pkg::BS_W-1:0]    bs,
	input  bsr_pkg::cmd_t               cmd,
	input  logic                        cmd_empty,
	output logic                        cmd_pop,
	output logic                        ram_re,
	output logic [ADDR_W-1:0]           ram_raddr,
	input  logic [bsr_pkg::VAL_W-1:0]   ram_rdata,
	output logic                        blk_read_done,
	output bsr_pkg::result_t            res,
	output logic                        res_empty,
	input  logic                        res_pop
);

	localparam int CW  = bsr_pkg::CFG_W;
	localparam int BW  = bsr_pkg::BS_W;
	localparam int NW  = bsr_pkg::CNT_W;
	localparam int RCW = $clog2(bsr_pkg::RES_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_COL,
		ST_VAL,
		ST_END
	} state_t;

	state_t            state_q;
	bsr_pkg::cmd_t     cmd_q;
	logic [BW-1:0]     i_q;
	logic [BW-1:0]     j_q;
	logic [ADDR_W-1:0] rowoff_q;
	logic [CW-1:0]     col_q;

	logic                 v_s1;
	bsr_pkg::kind_t       kind_s1;
	logic [NW-1:0]        pos_s1;
	logic                 last_s1;
	logic                 isval_s1;

	logic                 room;
	logic                 emit;
	logic                 vlast;
	bsr_pkg::kind_t       e_kind;
	logic [NW-1:0]        e_pos;
	logic                 e_last;
	logic [RCW-1:0]       res_cnt;
	bsr_pkg::result_t     res_in;
	logic [$bits(bsr_pkg::result_t)-1:0] res_bits;

	// Pick the next result of the current request
	always_comb begin
		room    = (32'(res_cnt) + 32'(v_s1)) < bsr_pkg::RES_DEPTH;
		emit    = room && (state_q != ST_IDLE);
		vlast   = (i_q == bs - BW'(1)) && (j_q == bs - BW'(1));
		cmd_pop = (state_q == ST_IDLE) && !cmd_empty;
		e_kind  = bsr_pkg::KIND_PTR;
		e_pos   = '0;
		e_last  = 1'b0;
		case (state_q)
			ST_START: begin
				e_pos  = cmd_q.start_cnt;
				e_last = !cmd_q.has_block && !cmd_q.has_end;
			end
			ST_COL: begin
				e_kind = bsr_pkg::KIND_COL;
				e_pos  = NW'(cmd_q.blk_col);
			end
			ST_VAL: begin
				e_kind = bsr_pkg::KIND_VAL;
				e_last = vlast && !cmd_q.has_end;
			end
			ST_END: begin
				e_pos  = cmd_q.end_cnt;
				e_last = 1'b1;
			end
			default: begin
				e_kind = bsr_pkg::KIND_PTR;
			end
		endcase
		ram_re        = emit && (state_q == ST_VAL);
		ram_raddr     = rowoff_q + ADDR_W'(col_q);
		blk_read_done = ram_re && vlast;
	end

	// Sequence the request and register each result with the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			v_s1    <= 1'b0;
		end else begin
			v_s1     <= emit;
			kind_s1  <= e_kind;
			pos_s1   <= e_pos;
			last_s1  <= e_last;
			isval_s1 <= (state_q == ST_VAL);
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						cmd_q <= cmd;
						if (cmd.has_start) begin
							state_q <= ST_START;
						end else if (cmd.has_block) begin
							state_q <= ST_COL;
						end else begin
							state_q <= ST_END;
						end
					end
				end
				ST_START: begin
					if (emit) begin
						if (cmd_q.has_block) begin
							state_q <= ST_COL;
						end else if (cmd_q.has_end) begin
							state_q <= ST_END;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_COL: begin
					if (emit) begin
						state_q  <= ST_VAL;
						i_q      <= '0;
						j_q      <= '0;
						rowoff_q <= '0;
						col_q    <= cmd_q.col0;
					end
				end
				ST_VAL: begin
					if (emit) begin
						if (j_q == bs - BW'(1)) begin
							j_q   <= '0;
							col_q <= cmd_q.col0;
							if (i_q == bs - BW'(1)) begin
								state_q <= cmd_q.has_end ? ST_END : ST_IDLE;
							end else begin
								i_q      <= i_q + BW'(1);
								rowoff_q <= rowoff_q + ADDR_W'(MAX_COLS);
							end
						end else begin
							j_q   <= j_q + BW'(1);
							col_q <= col_q + CW'(1);
						end
					end
				end
				ST_END: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Join the store data and queue the result
	always_comb begin
		res_in.kind  = kind_s1;
		res_in.pos   = pos_s1;
		res_in.value = isval_s1 ? ram_rdata : '0;
		res_in.last  = last_s1;
	end

	bsr_fifo #(
		.WIDTH ($bits(bsr_pkg::result_t)),
		.DEPTH (bsr_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s1),
		.wdata  (res_in),
		.full   (),
		.pop    (res_pop),
		.rdata  (res_bits),
		.empty  (res_empty),
		.count  (res_cnt)
	);

	assign res = bsr_pkg::result_t'(res_bits);

endmodule

FILE: hdl/dense_to_bsr_converter.sv
// A result passes through the request queue, back end state, result register and result
// queue. One element per cycle in while full is low; one result per cycle out while the
// result queue has room, none while a request is fetched. An element that writes a block
// still being read, or closes a block meanwhile, waits until the last read.
// Reset (arst_n, asynchronous): clears positions, marks, block total and both queues;
// registers go to 256 rows, 256 columns, block size 2. The block row store is not cleared.
module dense_to_bsr_converter #(
	parameter int MAX_ROWS  = bsr_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS  = bsr_pkg::MAX_COLS_DEF,
	parameter int MAX_BLOCK = bsr_pkg::MAX_BLOCK_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] element_value,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         item_kind,
	output logic [16:0]        position,
	output logic signed [31:0] block_value,
	output logic               run_last
);

	localparam int CW        = bsr_pkg::CFG_W;
	localparam int BW        = bsr_pkg::BS_W;
	localparam int ST_DEPTH  = MAX_BLOCK * MAX_COLS;
	localparam int ADDR_W    = $clog2(ST_DEPTH > 1 ? ST_DEPTH : 2);

	logic [CW-1:0] row_count_q;
	logic [CW-1:0] column_count_q;
	logic [BW-1:0] block_size_q;
	logic [CW-1:0] rows_eff;
	logic [CW-1:0] cols_eff;
	logic [BW-1:0] bs_eff;
	logic          cfg_wr;
	logic          restart;

	bsr_pkg::cmd_t    cmd_in;
	bsr_pkg::cmd_t    cmd_out;
	logic [$bits(bsr_pkg::cmd_t)-1:0] cmd_bits;
	logic             cmd_push;
	logic             cmd_full;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [31:0]      ram_wdata;
	logic             ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [31:0]      ram_rdata;
	logic             blk_read_done;
	bsr_pkg::result_t res;

	// Decode register writes
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign restart = cfg_wr && ((paddr[3:2] == bsr_pkg::REG_ROW_COUNT) ||
		(paddr[3:2] == bsr_pkg::REG_COLUMN_COUNT) ||
		(paddr[3:2] == bsr_pkg::REG_BLOCK_SIZE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= bsr_pkg::RESET_ROW_COUNT;
			column_count_q <= bsr_pkg::RESET_COLUMN_COUNT;
			block_size_q   <= bsr_pkg::RESET_BLOCK_SIZE;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				bsr_pkg::REG_ROW_COUNT:    row_count_q    <= pwdata[CW-1:0];
				bsr_pkg::REG_COLUMN_COUNT: column_count_q <= pwdata[CW-1:0];
				bsr_pkg::REG_BLOCK_SIZE:   block_size_q   <= pwdata[BW-1:0];
				default: begin
					row_count_q <= row_count_q;
				end
			endcase
		end
	end

	// Return register contents
	always_comb begin
		case (paddr[3:2])
			bsr_pkg::REG_ROW_COUNT:    prdata = 32'(row_count_q);
			bsr_pkg::REG_COLUMN_COUNT: prdata = 32'(column_count_q);
			bsr_pkg::REG_BLOCK_SIZE:   prdata = 32'(block_size_q);
			default:                   prdata = '0;
		endcase
	end

	// Clamp registers: zero acts as one, large values act as the maximum
	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = CW'(1);
		end else if (32'(row_count_q) > MAX_ROWS) begin
			rows_eff = CW'(MAX_ROWS);
		end else begin
			rows_eff = row_count_q;
		end
		if (column_count_q == '0) begin
			cols_eff = CW'(1);
		end else if (32'(column_count_q) > MAX_COLS) begin
			cols_eff = CW'(MAX_COLS);
		end else begin
			cols_eff = column_count_q;
		end
		if (block_size_q == '0) begin
			bs_eff = BW'(1);
		end else if (32'(block_size_q) > MAX_BLOCK) begin
			bs_eff = BW'(MAX_BLOCK);
		end else begin
			bs_eff = block_size_q;
		end
	end

	bsr_front #(
		.MAX_COLS (MAX_COLS),
		.ADDR_W   (ADDR_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (restart),
		.rows          (rows_eff),
		.cols          (cols_eff),
		.bs            (bs_eff),
		.push          (push),
		.element_value (element_value),
		.full          (full),
		.cmd           (cmd_in),
		.cmd_push      (cmd_push),
		.cmd_full      (cmd_full),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.blk_read_done (blk_read_done)
	);

	bsr_fifo #(
		.WIDTH ($bits(bsr_pkg::cmd_t)),
		.DEPTH (bsr_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_bits),
		.empty  (cmd_empty),
		.count  ()
	);

	assign cmd_out = bsr_pkg::cmd_t'(cmd_bits);

	bsr_ram #(
		.WIDTH (32),
		.DEPTH (ST_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bsr_back #(
		.MAX_COLS (MAX_COLS),
		.ADDR_W   (ADDR_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.bs            (bs_eff),
		.cmd           (cmd_out),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.blk_read_done (blk_read_done),
		.res           (res),
		.res_empty     (empty),
		.res_pop       (pop)
	);

	// Drive result ports from the head of the result queue
	assign item_kind   = res.kind;
	assign position    = res.pos;
	assign block_value = res.value;
	assign run_last    = res.last;

`ifndef SYNTHESIS
	a_value_only_on_val: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (item_kind != bsr_pkg::KIND_VAL) |-> block_value == '0)
		else $error("nonzero value on a pointer or column result");

	a_pos_zero_on_val: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (item_kind == bsr_pkg::KIND_VAL) |-> position == '0)
		else $error("nonzero position on a value result");

	a_col_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (item_kind == bsr_pkg::KIND_COL) |-> !run_last)
		else $error("column result marked as last of its request");
`endif

endmodule
